FILE: rtl/core/sgd_pkg.sv
// ----------------------------------------------------------------------------
// sgd_pkg
// Shared types and constants for the switch gesture detector.
// ----------------------------------------------------------------------------
`default_nettype none

package sgd_pkg;

  // Width of the internal tick counters.
  localparam int unsigned TimerBits = 16;
  // Width of the configured tick thresholds.
  localparam int unsigned ThreshBits = 16;
  // Common width used to compare a count with its threshold.
  localparam int unsigned CmpBits = (TimerBits > ThreshBits) ? TimerBits : ThreshBits;

  localparam int unsigned PosBits   = 8;
  localparam int unsigned CountBits = 8;
  localparam int unsigned AddrBits  = 4;
  localparam int unsigned DataBits  = 32;

  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_TICK    = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_INITIAL  = 3'd1,
    EV_LONG     = 3'd2,
    EV_LONG_REL = 3'd3,
    EV_MP_DONE  = 3'd4
  } event_e;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_WAIT_LONG = 3'd1,
    ST_LONG_ON   = 3'd2,
    ST_MP_REL    = 3'd3,
    ST_MP_PRESS  = 3'd4
  } gesture_e;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_LONG_EN    = 2'd0,
    REG_LONG_TICKS = 2'd1,
    REG_IDLE_TICKS = 2'd2,
    REG_MP_LIMIT   = 2'd3
  } reg_e;

  typedef struct packed {
    logic                  long_press_enable;
    logic [ThreshBits-1:0] long_press_ticks;
    logic [ThreshBits-1:0] idle_ticks;
    logic [CountBits-1:0]  multi_press_limit;
  } cfg_t;

  // Control from the gesture logic to one tick timer.
  typedef struct packed {
    logic start;
    logic stop;
  } tmr_ctrl_t;

  typedef struct packed {
    logic [PosBits-1:0]   current_position;
    event_e               event_kind;
    logic [PosBits-1:0]   event_position;
    logic [CountBits-1:0] press_total;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/sgd_cfg.sv
// ----------------------------------------------------------------------------
// sgd_cfg
// Configuration register file behind a simple APB-style slave port.
// ----------------------------------------------------------------------------
`default_nettype none

module sgd_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sgd_pkg::AddrBits-1:0] paddr,
  input  wire logic [sgd_pkg::DataBits-1:0] pwdata,
  output logic      [sgd_pkg::DataBits-1:0] prdata,
  output logic                              pready,
  output sgd_pkg::cfg_t                     cfg_o
);
  import sgd_pkg::*;

  cfg_t cfg_q;
  logic wr_en;
  reg_e reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = reg_e'(paddr[AddrBits-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_enable <= 1'b1;
      cfg_q.long_press_ticks  <= ThreshBits'(1000);
      cfg_q.idle_ticks        <= ThreshBits'(300);
      cfg_q.multi_press_limit <= CountBits'(2);
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_LONG_EN:    cfg_q.long_press_enable <= pwdata[0];
        REG_LONG_TICKS: cfg_q.long_press_ticks  <= pwdata[ThreshBits-1:0];
        REG_IDLE_TICKS: cfg_q.idle_ticks        <= pwdata[ThreshBits-1:0];
        REG_MP_LIMIT:   cfg_q.multi_press_limit <= pwdata[CountBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_LONG_EN:    prdata = DataBits'(cfg_q.long_press_enable);
      REG_LONG_TICKS: prdata = DataBits'(cfg_q.long_press_ticks);
      REG_IDLE_TICKS: prdata = DataBits'(cfg_q.idle_ticks);
      REG_MP_LIMIT:   prdata = DataBits'(cfg_q.multi_press_limit);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/core/sgd_timer.sv
// ----------------------------------------------------------------------------
// sgd_timer
// Saturating tick counter that expires when it reaches its threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module sgd_timer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           tick_i,
  input  wire logic [sgd_pkg::ThreshBits-1:0] limit_i,
  input  wire sgd_pkg::tmr_ctrl_t             ctrl_i,
  output logic                                expire_o
);
  import sgd_pkg::*;

  localparam logic [TimerBits-1:0] CountMax = {TimerBits{1'b1}};

  logic [TimerBits-1:0] cnt_q, cnt_d, cnt_inc;
  logic                 on_q, on_d;

  // The count saturates; a saturated counter expires whatever the threshold.
  assign cnt_inc  = (cnt_q == CountMax) ? cnt_q : cnt_q + 1'b1;
  assign expire_o = tick_i & on_q &
                    ((CmpBits'(cnt_inc) >= CmpBits'(limit_i)) | (cnt_inc == CountMax));

  always_comb begin
    cnt_d = cnt_q;
    on_d  = on_q;
    if (tick_i && on_q) begin
      cnt_d = cnt_inc;
      if (expire_o) begin
        on_d = 1'b0;
      end
    end
    if (ctrl_i.start) begin
      cnt_d = '0;
      on_d  = 1'b1;
    end else if (ctrl_i.stop) begin
      on_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      on_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      on_q  <= on_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sgd_fsm.sv
// ----------------------------------------------------------------------------
// sgd_fsm
// Gesture state machine: position tracking, press counting and events.
// ----------------------------------------------------------------------------
`default_nettype none

module sgd_fsm (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic [1:0]                  op_i,
  input  wire logic [sgd_pkg::PosBits-1:0] pos_i,
  input  wire sgd_pkg::cfg_t               cfg_i,
  input  wire logic                        long_hit_i,
  input  wire logic                        idle_hit_i,
  output sgd_pkg::tmr_ctrl_t               long_ctrl_o,
  output sgd_pkg::tmr_ctrl_t               idle_ctrl_o,
  output sgd_pkg::result_t                 result_o
);
  import sgd_pkg::*;

  gesture_e             state_q, state_d;
  logic [PosBits-1:0]   held_q, held_d;
  logic [PosBits-1:0]   shown_q, shown_d;
  logic [CountBits-1:0] count_q, count_d;
  logic                 limit_q, limit_d;
  op_e                  op;

  assign op = op_e'(op_i);

  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    shown_d     = shown_q;
    count_d     = count_q;
    limit_d     = limit_q;
    long_ctrl_o = '0;
    idle_ctrl_o = '0;
    result_o    = '0;
    result_o.event_kind = EV_NONE;

    case (op)
      OP_PRESS:   shown_d = pos_i;
      OP_RELEASE: shown_d = '0;
      default:    shown_d = shown_q;
    endcase

    unique case (state_q)
      ST_WAIT_LONG: begin
        if (op == OP_RELEASE) begin
          state_d           = ST_MP_REL;
          long_ctrl_o.stop  = 1'b1;
          idle_ctrl_o.start = 1'b1;
        end else if (long_hit_i) begin
          state_d                 = ST_LONG_ON;
          result_o.event_kind     = EV_LONG;
          result_o.event_position = held_q;
        end
      end
      ST_LONG_ON: begin
        if (op == OP_RELEASE) begin
          result_o.event_kind     = EV_LONG_REL;
          result_o.event_position = held_q;
          state_d                 = ST_IDLE;
          held_d                  = '0;
          limit_d                 = 1'b0;
        end
      end
      ST_MP_REL: begin
        if (op == OP_PRESS) begin
          state_d          = ST_MP_PRESS;
          idle_ctrl_o.stop = 1'b1;
          if (count_q != cfg_i.multi_press_limit && count_q != {CountBits{1'b1}}) begin
            count_d = count_q + 1'b1;
          end else begin
            limit_d = 1'b1;
          end
        end else if (idle_hit_i) begin
          result_o.event_kind     = EV_MP_DONE;
          result_o.event_position = held_q;
          result_o.press_total    = limit_q ? '0 : count_q;
          state_d                 = ST_IDLE;
          held_d                  = '0;
          limit_d                 = 1'b0;
        end
      end
      ST_MP_PRESS: begin
        if (op == OP_RELEASE) begin
          state_d           = ST_MP_REL;
          long_ctrl_o.stop  = 1'b1;
          idle_ctrl_o.start = 1'b1;
        end
      end
      default: begin
        if (op == OP_PRESS) begin
          held_d                  = pos_i;
          state_d                 = ST_WAIT_LONG;
          count_d                 = CountBits'(1);
          result_o.event_kind     = EV_INITIAL;
          result_o.event_position = pos_i;
          long_ctrl_o.start       = cfg_i.long_press_enable;
        end
      end
    endcase

    result_o.current_position = shown_d;

    if (!step_i) begin
      state_d     = state_q;
      held_d      = held_q;
      shown_d     = shown_q;
      count_d     = count_q;
      limit_d     = limit_q;
      long_ctrl_o = '0;
      idle_ctrl_o = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      held_q  <= '0;
      shown_q <= '0;
      count_q <= '0;
      limit_q <= 1'b0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      shown_q <= shown_d;
      count_q <= count_d;
      limit_q <= limit_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/switch_gesture_detector.sv
// ----------------------------------------------------------------------------
// switch_gesture_detector
// Press, long-press and multi-press gesture detector for one switch.
// ----------------------------------------------------------------------------
// Usage: each input beat carries an op (press, release or one timer tick)
// and, for a press, the switch position. Every input beat produces exactly
// one output beat with the position now shown, the gesture event (if any),
// the position it refers to and, for a finished multi-press, the count.
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low. The input beat is captured in an input register, the gesture
// logic and the two tick timers work on it, and the result is held in an
// output register: the result is offered once the beat has moved from the
// input register into the output register, and one beat per cycle is
// sustained while the receiver does not stall. When the receiver stalls,
// the output register holds its beat and the input register holds the
// next one; the input stall then rises, so at most two beats are in
// flight. Reset (rst_ni low, asynchronous) empties both registers,
// returns the gesture to idle with the timers stopped and loads the
// register defaults: long press enabled, 1000 long-press ticks, 300 idle
// ticks and a multi-press limit of two. Registers must be written via
// the APB-style port only while no beat is in flight; the block itself
// does not enforce this. pready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module switch_gesture_detector (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sgd_pkg::AddrBits-1:0]  paddr,
  input  wire logic [sgd_pkg::DataBits-1:0]  pwdata,
  output logic      [sgd_pkg::DataBits-1:0]  prdata,
  output logic                               pready,
  // Input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    op_i,
  input  wire logic [sgd_pkg::PosBits-1:0]   position_i,
  // Output channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [sgd_pkg::PosBits-1:0]   current_position_o,
  output logic      [2:0]                    event_kind_o,
  output logic      [sgd_pkg::PosBits-1:0]   event_position_o,
  output logic      [sgd_pkg::CountBits-1:0] press_total_o
);
  import sgd_pkg::*;

  cfg_t      cfg;
  tmr_ctrl_t long_ctrl, idle_ctrl;
  result_t   result;
  logic      long_hit, idle_hit, idle_tick;

  // Input register.
  logic               in_vld_q;
  logic [1:0]         in_op_q;
  logic [PosBits-1:0] in_pos_q;

  // Output register.
  logic    out_vld_q;
  result_t out_q;

  logic step;      // the held input beat moves into the output register
  logic out_free;  // the output register can take a beat this cycle
  logic tick;

  assign out_free   = ~out_vld_q | ~out_stall_i;
  assign step       = in_vld_q & out_free;
  assign in_stall_o = in_vld_q & ~out_free;
  assign tick       = step & (op_e'(in_op_q) == OP_TICK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_op_q  <= op_i;
      in_pos_q <= position_i;
    end
  end

  sgd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The long timer is checked first; the idle timer only sees a tick that
  // did not expire the long timer.
  sgd_timer u_long_tmr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick),
    .limit_i  (cfg.long_press_ticks),
    .ctrl_i   (long_ctrl),
    .expire_o (long_hit)
  );

  assign idle_tick = tick & ~long_hit;

  sgd_timer u_idle_tmr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (idle_tick),
    .limit_i  (cfg.idle_ticks),
    .ctrl_i   (idle_ctrl),
    .expire_o (idle_hit)
  );

  sgd_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .op_i        (in_op_q),
    .pos_i       (in_pos_q),
    .cfg_i       (cfg),
    .long_hit_i  (long_hit),
    .idle_hit_i  (idle_hit),
    .long_ctrl_o (long_ctrl),
    .idle_ctrl_o (idle_ctrl),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign current_position_o = out_q.current_position;
  assign event_kind_o       = out_q.event_kind;
  assign event_position_o   = out_q.event_position;
  assign press_total_o      = out_q.press_total;

endmodule

`default_nettype wire

FILE: test/tb_switch_gesture_detector.sv
// ----------------------------------------------------------------------------
// tb_switch_gesture_detector
// Self-checking bench for the switch gesture detector.
// ----------------------------------------------------------------------------
// A queue of press, release and tick beats is filled by the stimulus process.
// A clocked driver sends the beats and a clocked monitor checks the results.
// The monitor predicts the result of every accepted input beat with a
// behavioural copy of the gesture logic and its two tick timers. Each output
// beat is compared field by field with the oldest prediction. The stimulus
// begins with a short directed sequence. Random phases follow with different
// register settings: mostly well-formed gestures with random timing, plus
// stray beats. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb_switch_gesture_detector;
  timeunit 1ns;
  timeprecision 1ps;

  import sgd_pkg::*;

  // The spare op encoding, which the block must ignore.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         op;
    logic [PosBits-1:0] pos;
  } switch_beat_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [AddrBits-1:0]   paddr = '0;
  logic [DataBits-1:0]   pwdata = '0;
  logic [DataBits-1:0]   prdata;
  logic                  pready;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [1:0]            op_i = 2'd0;
  logic [PosBits-1:0]    position_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [PosBits-1:0]    current_position_o;
  logic [2:0]            event_kind_o;
  logic [PosBits-1:0]    event_position_o;
  logic [CountBits-1:0]  press_total_o;

  switch_gesture_detector DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .op_i               (op_i),
    .position_i         (position_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .current_position_o (current_position_o),
    .event_kind_o       (event_kind_o),
    .event_position_o   (event_position_o),
    .press_total_o      (press_total_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Beats waiting to be sent, and results predicted for accepted beats.
  switch_beat_t     pending_beats[$];
  result_t          expected_results[$];
  int               mismatches = 0;
  int               queued = 0;
  // When set, neither side idles: this gives stretches at full rate.
  bit               steady = 1'b0;
  bit               beat_taken = 1'b0;
  int               send_gap = 0;
  int               stall_left = 0;
  switch_beat_t     next_beat;
  result_t          want;

  // Register values as the block should hold them, starting at the
  // reset defaults.
  cfg_t             live_cfg = '{1'b1, 16'd1000, 16'd300, 8'd2};

  // Gesture state as the block should hold it.
  gesture_e               gesture_now = ST_IDLE;
  logic [PosBits-1:0]     held_pos = '0;
  logic [PosBits-1:0]     shown_pos = '0;
  logic [CountBits-1:0]   press_count = '0;
  logic                   over_limit = 1'b0;
  logic [TimerBits-1:0]   long_count = '0;
  logic                   long_running = 1'b0;
  logic [TimerBits-1:0]   idle_count = '0;
  logic                   idle_running = 1'b0;

  // Applies one input beat to the gesture state and returns the result that
  // the block must produce for it.
  function automatic result_t advance_gesture(logic [1:0] op, logic [PosBits-1:0] pos);
    result_t r;
    logic    long_hit;
    logic    idle_hit;
    r = '0;
    r.event_kind = EV_NONE;
    long_hit = 1'b0;
    idle_hit = 1'b0;

    if (op == OP_PRESS) begin
      shown_pos = pos;
    end else if (op == OP_RELEASE) begin
      shown_pos = '0;
    end else if (op == OP_TICK) begin
      // A running timer counts up, saturating, and stops once it has reached
      // its threshold. The long timer is looked at first.
      if (long_running) begin
        if (long_count != '1) long_count = long_count + 1'b1;
        if (long_count >= live_cfg.long_press_ticks || long_count == '1) begin
          long_running = 1'b0;
          long_hit = 1'b1;
        end
      end
      if (!long_hit && idle_running) begin
        if (idle_count != '1) idle_count = idle_count + 1'b1;
        if (idle_count >= live_cfg.idle_ticks || idle_count == '1) begin
          idle_running = 1'b0;
          idle_hit = 1'b1;
        end
      end
    end

    case (gesture_now)
      ST_WAIT_LONG: begin
        if (op == OP_RELEASE) begin
          gesture_now = ST_MP_REL;
          long_running = 1'b0;
          idle_count = '0;
          idle_running = 1'b1;
        end else if (long_hit) begin
          gesture_now = ST_LONG_ON;
          r.event_kind = EV_LONG;
          r.event_position = held_pos;
        end
      end
      ST_LONG_ON: begin
        if (op == OP_RELEASE) begin
          r.event_kind = EV_LONG_REL;
          r.event_position = held_pos;
          gesture_now = ST_IDLE;
          held_pos = '0;
          over_limit = 1'b0;
        end
      end
      ST_MP_REL: begin
        if (op == OP_PRESS) begin
          gesture_now = ST_MP_PRESS;
          idle_running = 1'b0;
          if (press_count != live_cfg.multi_press_limit && press_count != '1) begin
            press_count = press_count + 1'b1;
          end else begin
            over_limit = 1'b1;
          end
        end else if (idle_hit) begin
          r.event_kind = EV_MP_DONE;
          r.event_position = held_pos;
          r.press_total = over_limit ? '0 : press_count;
          gesture_now = ST_IDLE;
          held_pos = '0;
          over_limit = 1'b0;
        end
      end
      ST_MP_PRESS: begin
        if (op == OP_RELEASE) begin
          gesture_now = ST_MP_REL;
          long_running = 1'b0;
          idle_count = '0;
          idle_running = 1'b1;
        end
      end
      default: begin
        // Idle: only a press starts a gesture.
        if (op == OP_PRESS) begin
          held_pos = pos;
          gesture_now = ST_WAIT_LONG;
          press_count = CountBits'(1);
          r.event_kind = EV_INITIAL;
          r.event_position = pos;
          if (live_cfg.long_press_enable) begin
            long_count = '0;
            long_running = 1'b1;
          end
        end
      end
    endcase

    r.current_position = shown_pos;
    return r;
  endfunction

  // Idle lengths for both channels: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Driver: a beat stays on the port until the monitor has seen it taken,
  // then the next one follows after a random gap.
  always @(negedge clk_i) begin
    if (!(in_valid_i && !beat_taken)) begin
      beat_taken = 1'b0;
      if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap--;
      end else if (pending_beats.size() > 0) begin
        next_beat = pending_beats.pop_front();
        op_i <= next_beat.op;
        position_i <= next_beat.pos;
        in_valid_i <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, changed on the falling edge like every input.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = pick_gap();
    end
  end

  // Monitor: checks each output beat against the oldest prediction, and
  // predicts the result of each input beat as it is accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("output beat with no result expected");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (current_position_o !== want.current_position) begin
            $error("current_position: expected %0d, got %0d",
                   want.current_position, current_position_o);
            mismatches++;
          end
          if (event_kind_o !== want.event_kind) begin
            $error("event_kind: expected %0d, got %0d", want.event_kind, event_kind_o);
            mismatches++;
          end
          if (event_position_o !== want.event_position) begin
            $error("event_position: expected %0d, got %0d",
                   want.event_position, event_position_o);
            mismatches++;
          end
          if (press_total_o !== want.press_total) begin
            $error("press_total: expected %0d, got %0d", want.press_total, press_total_o);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(advance_gesture(op_i, position_i));
        beat_taken = 1'b1;
      end
    end
  end

  task automatic push_beat(logic [1:0] op, logic [PosBits-1:0] pos);
    switch_beat_t b;
    b.op = op;
    b.pos = pos;
    pending_beats.push_back(b);
    queued++;
  endtask

  // Positions favour both extremes so that every bit is seen both ways.
  function automatic logic [PosBits-1:0] pick_position();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PosBits'($urandom_range(0, 255));
  endfunction

  // Filler for the position field of beats that ignore it.
  function automatic logic [PosBits-1:0] any_byte();
    return PosBits'($urandom_range(0, 255));
  endfunction

  // A number of ticks around a threshold, so that timers both expire and
  // get cut short. Large thresholds only see a handful.
  function automatic int tick_span(logic [15:0] thr);
    if (thr > 12) return $urandom_range(0, 12);
    return $urandom_range(0, thr + 1);
  endfunction

  // Waits until every beat has been sent and every result has arrived,
  // then lets the pipeline settle.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_beats.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // One APB write: setup cycle, then access cycle.
  task automatic write_reg(reg_e idx, logic [DataBits-1:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LONG_EN:    live_cfg.long_press_enable = val[0];
      REG_LONG_TICKS: live_cfg.long_press_ticks = val[15:0];
      REG_IDLE_TICKS: live_cfg.idle_ticks = val[15:0];
      REG_MP_LIMIT:   live_cfg.multi_press_limit = val[7:0];
      default: ;
    endcase
  endtask

  // Writes all four registers. The unused upper data bits carry junk, which
  // the block must drop.
  task automatic configure(logic en, logic [15:0] lt, logic [15:0] it, logic [7:0] lim);
    write_reg(REG_LONG_EN, ($urandom & 32'hFFFF_FFFE) | en);
    write_reg(REG_LONG_TICKS, ($urandom & 32'hFFFF_0000) | lt);
    write_reg(REG_IDLE_TICKS, ($urandom & 32'hFFFF_0000) | it);
    write_reg(REG_MP_LIMIT, ($urandom & 32'hFFFF_FF00) | lim);
  endtask

  // One gesture: a first press held for a while, possibly further presses,
  // and a run of ticks that usually lets the idle timer finish it.
  task automatic queue_gesture();
    int extra;
    int ending;
    push_beat(OP_PRESS, pick_position());
    repeat (tick_span(live_cfg.long_press_ticks)) begin
      if ($urandom_range(0, 5) == 0) push_beat(OP_PRESS, pick_position());
      push_beat(OP_TICK, any_byte());
    end
    push_beat(OP_RELEASE, any_byte());
    extra = $urandom_range(0, (live_cfg.multi_press_limit > 4) ? 5 :
                              live_cfg.multi_press_limit + 1);
    repeat (extra) begin
      repeat (tick_span(live_cfg.idle_ticks)) push_beat(OP_TICK, any_byte());
      push_beat(OP_PRESS, pick_position());
      repeat ($urandom_range(0, 2)) push_beat(OP_TICK, any_byte());
      push_beat(OP_RELEASE, any_byte());
      if ($urandom_range(0, 5) == 0) push_beat(OP_RELEASE, any_byte());
    end
    ending = (live_cfg.idle_ticks <= 12) ? live_cfg.idle_ticks + $urandom_range(0, 1)
                                         : $urandom_range(0, 12);
    repeat (ending) push_beat(OP_TICK, any_byte());
  endtask

  // A random phase of roughly n beats. With pause_midway the sender holds
  // back half way until every result is in.
  task automatic run_phase(int n, bit pause_midway);
    int stop_at;
    stop_at = queued + n;
    steady = ($urandom_range(0, 3) == 0);
    while (queued < stop_at) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) push_beat(2'($urandom_range(0, 3)), any_byte());
      end else begin
        queue_gesture();
      end
      if (pause_midway && queued >= stop_at - n / 2) begin
        wait_drained();
        pause_midway = 1'b0;
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // At the reset settings: a first press starts the long timer, and the
    // release before it expires leaves a multi-press sequence open.
    push_beat(OP_PRESS, 8'hFF);
    push_beat(OP_TICK, 8'h00);
    push_beat(OP_RELEASE, 8'h00);
    wait_drained();

    configure(1'b1, 16'd2, 16'd2, 8'd2);
    // The idle timer finishes the open sequence with a count of one.
    push_beat(OP_TICK, 8'hFF);
    push_beat(OP_TICK, 8'h00);
    // Long press, a press while already held, then the long release and a
    // release while already released.
    push_beat(OP_PRESS, 8'h00);
    push_beat(OP_TICK, 8'h00);
    push_beat(OP_TICK, 8'h00);
    push_beat(OP_PRESS, 8'hAA);
    push_beat(OP_RELEASE, 8'h00);
    push_beat(OP_RELEASE, 8'h00);
    // The spare op code must leave everything as it is.
    push_beat(OP_UNUSED, 8'h55);
    // Three presses against a limit of two: the count reported is zero.
    push_beat(OP_PRESS, 8'h55);
    push_beat(OP_RELEASE, 8'h00);
    push_beat(OP_PRESS, 8'h0F);
    push_beat(OP_RELEASE, 8'h00);
    push_beat(OP_PRESS, 8'hF0);
    push_beat(OP_RELEASE, 8'h00);
    push_beat(OP_TICK, 8'h00);
    push_beat(OP_TICK, 8'h00);
    push_beat(OP_TICK, 8'h00);
    wait_drained();

    // Long-press detection off: every gesture is a multi-press one.
    configure(1'b0, 16'd5, 16'd3, 8'd3);
    run_phase(140, 1'b0);

    // Zero thresholds behave like one; the sender also pauses mid-phase.
    configure(1'b1, 16'd0, 16'd0, 8'd1);
    run_phase(140, 1'b1);

    // Largest settings: the timers hardly ever expire here. A press left
    // held at the end keeps its long timer running into the next phase.
    configure(1'b1, 16'hFFFF, 16'hFFFF, 8'hFF);
    run_phase(60, 1'b0);
    push_beat(OP_RELEASE, 8'h00);
    push_beat(OP_PRESS, pick_position());
    wait_drained();

    // Long-press detection switched off while that timer still runs.
    configure(1'b0, 16'd4, 16'd2, 8'd8);
    run_phase(100, 1'b0);

    // A limit of zero: the count climbs until the counter is full, which
    // also counts as the limit reached.
    configure(1'b1, 16'd3, 16'd2, 8'd0);
    steady = 1'b1;
    push_beat(OP_PRESS, pick_position());
    repeat (260) begin
      push_beat(OP_RELEASE, any_byte());
      push_beat(OP_PRESS, pick_position());
    end
    push_beat(OP_RELEASE, 8'h00);
    repeat (3) push_beat(OP_TICK, any_byte());
    wait_drained();

    repeat (3) begin
      configure(1'($urandom_range(0, 1)), 16'($urandom_range(1, 8)),
                16'($urandom_range(1, 6)), 8'($urandom_range(1, 5)));
      run_phase(140, 1'b0);
    end

    repeat (10) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/sgd_pkg.sv
rtl/core/sgd_cfg.sv
rtl/core/sgd_timer.sv
rtl/core/sgd_fsm.sv
rtl/core/switch_gesture_detector.sv
test/tb_switch_gesture_detector.sv
